// ===== rtl/core/bgrd_pkg.sv =====
// Shared types and constants for the button gesture reset detector.
package bgrd_pkg;

  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned StateWidth = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_FIRST_HOLD  = 3'd0,
    REG_MIN_PRESS   = 3'd1,
    REG_SETTLE      = 3'd2,
    REG_GIVE_UP     = 3'd3,
    REG_SECOND_HOLD = 3'd4,
    REG_FAST_BLINK  = 3'd5,
    REG_SLOW_BLINK  = 3'd6
  } cfg_reg_e;

  // Configuration reset values
  localparam logic [CfgWidth-1:0] FirstHoldRst  = 16'd5000;
  localparam logic [CfgWidth-1:0] MinPressRst   = 16'd100;
  localparam logic [CfgWidth-1:0] SettleRst     = 16'd100;
  localparam logic [CfgWidth-1:0] GiveUpRst     = 16'd10000;
  localparam logic [CfgWidth-1:0] SecondHoldRst = 16'd3000;
  localparam logic [CfgWidth-1:0] FastBlinkRst  = 16'd100;
  localparam logic [CfgWidth-1:0] SlowBlinkRst  = 16'd750;

  // One poll
  typedef struct packed {
    logic                 button_level;
    logic [TimeWidth-1:0] now_ms;
  } in_t;

  // One result
  typedef struct packed {
    logic                  led_on;
    logic                  announce_pulse;
    logic                  reset_pulse;
    logic [StateWidth-1:0] gesture_state;
  } out_t;

endpackage

// ===== rtl/core/button_gesture_reset_detector.sv =====
// Top level: push-button gesture detector with status LED, one poll per beat.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_data_i   (button_level, now_ms)
//  out     | output    | out_valid_o/out_ready_i| out_data_o  (led, pulses, state)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A poll beat is registered on entry, then passes through one combinational step
// into the result register; one beat per cycle is sustained while out does not stall.
// The gesture state advances when a poll moves from input to result register.
// A stall on out holds the result; the input register still takes a beat until full.
// Reset returns the machine to idle, LED off, times zero and registers to defaults.
// Configuration writes are taken every cycle; indexes beyond the list are dropped.
module button_gesture_reset_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bgrd_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bgrd_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bgrd_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [bgrd_pkg::CfgWidth-1:0]       cfg_data_i
);
  import bgrd_pkg::*;

  typedef enum logic [StateWidth-1:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSED = 3'd1,
    PH_LONG    = 3'd2,
    PH_WAIT    = 3'd3,
    PH_SECOND  = 3'd4,
    PH_ARMED   = 3'd5
  } phase_e;

  logic [CfgWidth-1:0] first_hold_q, min_press_q, settle_q, give_up_q;
  logic [CfgWidth-1:0] second_hold_q, fast_blink_q, slow_blink_q;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q, out_d;

  phase_e               phase_q, phase_d;
  logic [TimeWidth-1:0] mark_q, mark_d, blink_q, blink_d;
  logic                 led_q, led_d;

  logic                 advance;
  logic                 pressed;
  logic [TimeWidth-1:0] diff, blink_diff;
  logic                 announce, rst_pulse;

  // Handshake: input register refills when empty or draining this cycle
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_hold_q  <= FirstHoldRst;
      min_press_q   <= MinPressRst;
      settle_q      <= SettleRst;
      give_up_q     <= GiveUpRst;
      second_hold_q <= SecondHoldRst;
      fast_blink_q  <= FastBlinkRst;
      slow_blink_q  <= SlowBlinkRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FIRST_HOLD:  first_hold_q  <= cfg_data_i;
        REG_MIN_PRESS:   min_press_q   <= cfg_data_i;
        REG_SETTLE:      settle_q      <= cfg_data_i;
        REG_GIVE_UP:     give_up_q     <= cfg_data_i;
        REG_SECOND_HOLD: second_hold_q <= cfg_data_i;
        REG_FAST_BLINK:  fast_blink_q  <= cfg_data_i;
        REG_SLOW_BLINK:  slow_blink_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Gesture step: transition, then LED update
  always_comb begin
    pressed    = !in_q.button_level;
    diff       = in_q.now_ms - mark_q;
    blink_diff = in_q.now_ms - blink_q;
    phase_d    = phase_q;
    mark_d     = mark_q;
    blink_d    = blink_q;
    led_d      = led_q;
    announce   = 1'b0;
    rst_pulse  = 1'b0;

    unique case (phase_q)
      PH_PRESSED: begin
        if (pressed) begin
          if (diff > {16'd0, first_hold_q}) phase_d = PH_LONG;
        end else begin
          announce = (diff > {16'd0, min_press_q});
          phase_d  = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_d = PH_WAIT;
          mark_d  = in_q.now_ms;
        end
      end
      PH_WAIT: begin
        if (diff >= {16'd0, settle_q}) begin
          if (pressed) begin
            phase_d = PH_SECOND;
            mark_d  = in_q.now_ms;
          end else if (diff > {16'd0, give_up_q}) begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_SECOND: begin
        if (diff >= {16'd0, settle_q}) begin
          if (pressed) begin
            if (diff > {16'd0, second_hold_q}) phase_d = PH_ARMED;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_ARMED: begin
        if (!pressed) begin
          rst_pulse = 1'b1;
          phase_d   = PH_IDLE;
        end
      end
      default: begin
        phase_d = pressed ? PH_PRESSED : PH_IDLE;
        mark_d  = in_q.now_ms;
      end
    endcase

    unique case (phase_d)
      PH_PRESSED: led_d = 1'b1;
      PH_LONG, PH_WAIT, PH_SECOND: begin
        if (blink_diff > {16'd0, fast_blink_q}) begin
          led_d   = !led_q;
          blink_d = in_q.now_ms;
        end
      end
      PH_ARMED: begin
        if (blink_diff > {16'd0, slow_blink_q}) begin
          led_d   = !led_q;
          blink_d = in_q.now_ms;
        end
      end
      default: led_d = 1'b0;
    endcase

    out_d.led_on         = led_d;
    out_d.announce_pulse = announce;
    out_d.reset_pulse    = rst_pulse;
    out_d.gesture_state  = phase_d;
  end

  // Advance state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      mark_q      <= '0;
      blink_q     <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        mark_q  <= mark_d;
        blink_q <= blink_d;
        led_q   <= led_d;
        out_q   <= out_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pulses only leave the machine in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.announce_pulse || out_q.reset_pulse)) |->
      (out_q.gesture_state == PH_IDLE))
    else $error("pulse reported outside idle");

  // Idle means LED off, pressed means LED on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.gesture_state != PH_IDLE || !out_q.led_on) &&
                     (out_q.gesture_state != PH_PRESSED || out_q.led_on)))
    else $error("LED level does not match state");

  // A reset request comes only out of the armed state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rst_pulse |-> (phase_q == PH_ARMED))
    else $error("reset pulse without armed state");

  // State register and reported state agree after each step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_q.gesture_state == phase_q) && (out_q.led_on == led_q))
    else $error("result disagrees with state");

endmodule
